// File: rtl/cjtg_pkg.sv
package cjtg_pkg;

   localparam int AluW     = 64;
   localparam int MulSteps = 18;
   localparam int CntW     = 5;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [2:0] ST_SETPOINT = 3'd0;
   localparam logic [2:0] ST_STARTED  = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_ABORTED  = 3'd3;
   localparam logic [2:0] ST_FAULT    = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   localparam logic [1:0] CSR_PERIOD = 2'd0;
   localparam logic [1:0] CSR_MIN    = 2'd1;
   localparam logic [1:0] CSR_MAX    = 2'd2;
   localparam logic [1:0] CSR_LIMIT  = 2'd3;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic            start;
      alu_op_type      op;
      logic [AluW-1:0] a;
      logic [AluW-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic            done;
      logic [AluW-1:0] result;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PREP  = 5'b00010,
      S_JOINT = 5'b00100,
      S_EMIT  = 5'b01000,
      S_RESP  = 5'b10000
   } seq_state_type;

endpackage

// File: rtl/cjtg_alu.sv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module cjtg_alu #(
   parameter int QBITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cjtg_pkg::alu_cmd_type cmd,
   output cjtg_pkg::alu_rsp_type rsp
);
   import cjtg_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   alu_op_type          op_ff, op_in;
   logic [AluW-1:0]     acc_ff, acc_in;
   logic [AluW-1:0]     aa_ff, aa_in;
   logic [MulSteps-1:0] bb_ff, bb_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                ge;
   logic                last_step;

   assign ge = (acc_ff >= aa_ff);
   assign last_step = (op_ff == ALU_MUL) ? (cnt_ff == CntW'(MulSteps - 1))
                                         : (cnt_ff == CntW'(QBITS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      acc_in  = acc_ff;
      aa_in   = aa_ff;
      bb_in   = bb_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         if (cmd.op == ALU_MUL) begin
            acc_in = '0;
            aa_in  = cmd.a;
            bb_in  = cmd.b[MulSteps-1:0];
         end else begin
            // Divisor starts aligned to the top quotient bit.
            acc_in = cmd.a;
            aa_in  = cmd.b << (QBITS - 1);
            bb_in  = '0;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == ALU_MUL) begin
            if (bb_ff[0]) acc_in = acc_ff + aa_ff;
            aa_in = aa_ff << 1;
            bb_in = bb_ff >> 1;
         end else begin
            if (ge) acc_in = acc_ff - aa_ff;
            aa_in = aa_ff >> 1;
            bb_in = {bb_ff[MulSteps-2:0], ge};
         end
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      aa_ff  <= aa_in;
      bb_ff  <= bb_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = (op_ff == ALU_MUL) ? acc_ff : AluW'(bb_ff);

endmodule

// File: rtl/cubic_joint_trajectory_generator.sv
// Loads are written into the joint tables on acceptance; a start or clear moves to
// the response state, which registers the result once the output is free. A tick that
// runs the profile works through the one shared bit-serial multiply/divide unit
// (four common products, then one multiply and one divide per joint), then
// emits the setpoints one per joint; the final run skips the per-joint products.
// One item is in work at a time. Reset is synchronous and active high; stored joint positions are not cleared.
module cubic_joint_trajectory_generator #(
   parameter int JOINTS = 6,
   parameter int POSITION_BITS = 12,
   localparam int ReqW = ((53 + 2 * POSITION_BITS + 7) / 8) * 8,
   localparam int RspW = ((6 + POSITION_BITS + 7) / 8) * 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // operation, joint, start_position, target_position, duration, now_ms
   input  logic [ReqW-1:0] req_tdata,
   // halt
   input  logic [0:0]      req_tuser,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // status, joint_index_res, setpoint
   output logic [RspW-1:0] rsp_tdata,
   output logic            rsp_tlast,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata
);
   import cjtg_pkg::*;

   localparam int P        = POSITION_BITS;
   localparam int JW       = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int JointLo  = 2;
   localparam int StartLo  = 5;
   localparam int TargetLo = 5 + P;
   localparam int DurLo    = 5 + 2 * P;
   localparam int NowLo    = 21 + 2 * P;

   logic [1:0]  req_op;
   logic [2:0]  req_joint;
   logic [P-1:0] req_spos, req_tpos;
   logic [15:0] req_dur;
   logic [31:0] req_now;
   logic        req_halt;

   assign req_op    = req_tdata[1:0];
   assign req_joint = req_tdata[JointLo +: 3];
   assign req_spos  = req_tdata[StartLo +: P];
   assign req_tpos  = req_tdata[TargetLo +: P];
   assign req_dur   = req_tdata[DurLo +: 16];
   assign req_now   = req_tdata[NowLo +: 32];
   assign req_halt  = req_tuser[0];

   seq_state_type state_ff, state_in;
   logic [9:0]   period_ff;
   logic [15:0]  min_ff, max_ff;
   logic [P-1:0] limit_ff;
   logic         active_ff, active_in;
   logic         fault_ff, fault_in;
   logic [31:0]  mstart_ff, mstart_in;
   logic [15:0]  mdur_ff, mdur_in;
   logic [31:0]  lastrun_ff, lastrun_in;
   logic [31:0]  now_ff, now_in;
   logic [15:0]  e_ff, e_in;
   logic         done_ff, done_in;
   logic [31:0]  e2_ff, e2_in;
   logic [31:0]  d2_ff, d2_in;
   logic [47:0]  den_ff, den_in;
   logic [49:0]  num_ff, num_in;
   logic [JW-1:0] jix_ff, jix_in;
   logic [1:0]   step_ff, step_in;
   logic         wait_ff, wait_in;
   logic [2:0]   status_ff, status_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   rsp_status_ff, rsp_status_in;
   logic [2:0]   rsp_joint_ff, rsp_joint_in;
   logic [P-1:0] rsp_sp_ff, rsp_sp_in;
   logic         rsp_last_ff, rsp_last_in;

   logic [P-1:0] start_mem [JOINTS];
   logic [P-1:0] target_mem [JOINTS];
   logic [P-1:0] sp_ff [JOINTS];
   logic         load_we;
   logic         sp_we;
   logic [P-1:0] sp_val;

   alu_cmd_type alu_cmd;
   alu_rsp_type alu_rsp;

   cjtg_alu #(.QBITS(P)) u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

   logic         accept;
   logic         out_free;
   logic [31:0]  since_run;
   logic [31:0]  elapsed;
   logic [17:0]  kval;
   logic [P-1:0] js, jt, mag;
   logic         neg;
   logic [P:0]   vsum;
   logic [P-1:0] quo;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign since_run = req_now - lastrun_ff;
   assign elapsed   = req_now - mstart_ff;
   assign kval      = ({2'b0, mdur_ff} << 1) + {2'b0, mdur_ff} - ({2'b0, e_ff} << 1);
   assign js        = start_mem[jix_ff];
   assign jt        = target_mem[jix_ff];
   assign neg       = (jt < js);
   assign mag       = neg ? (js - jt) : (jt - js);
   assign quo       = alu_rsp.result[P-1:0];
   assign vsum      = done_ff ? {1'b0, jt}
                    : (neg ? ({1'b0, js} - {1'b0, quo}) : ({1'b0, js} + {1'b0, quo}));
   assign sp_val    = vsum[P-1:0];

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      fault_in      = fault_ff;
      mstart_in     = mstart_ff;
      mdur_in       = mdur_ff;
      lastrun_in    = lastrun_ff;
      now_in        = now_ff;
      e_in          = e_ff;
      done_in       = done_ff;
      e2_in         = e2_ff;
      d2_in         = d2_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      jix_in        = jix_ff;
      step_in       = step_ff;
      wait_in       = wait_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_joint_in  = rsp_joint_ff;
      rsp_sp_in     = rsp_sp_ff;
      rsp_last_in   = rsp_last_ff;
      load_we       = 1'b0;
      sp_we         = 1'b0;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = ALU_MUL;
      alu_cmd.a     = '0;
      alu_cmd.b     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_LOAD: begin
                     load_we = !active_ff && (32'(req_joint) < JOINTS);
                  end
                  OP_START: begin
                     state_in = S_RESP;
                     if (active_ff || fault_ff || req_dur < min_ff || req_dur > max_ff) begin
                        status_in = ST_REJECTED;
                     end else begin
                        status_in  = ST_STARTED;
                        active_in  = 1'b1;
                        mstart_in  = req_now;
                        mdur_in    = req_dur;
                        lastrun_in = req_now;
                     end
                  end
                  OP_CLEAR: begin
                     fault_in  = 1'b0;
                     status_in = ST_CLEARED;
                     state_in  = S_RESP;
                  end
                  OP_TICK: begin
                     if (active_ff) begin
                        if (req_halt) begin
                           active_in = 1'b0;
                           status_in = ST_ABORTED;
                           state_in  = S_RESP;
                        end else if (since_run >= 32'(period_ff)) begin
                           now_in   = req_now;
                           e_in     = (elapsed > 32'(mdur_ff)) ? mdur_ff : elapsed[15:0];
                           done_in  = (elapsed >= 32'(mdur_ff));
                           step_in  = '0;
                           wait_in  = 1'b0;
                           state_in = S_PREP;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PREP: begin
            if (!wait_ff) begin
               alu_cmd.start = 1'b1;
               wait_in       = 1'b1;
               unique case (step_ff)
                  2'd0: begin
                     alu_cmd.a = AluW'(e_ff);
                     alu_cmd.b = AluW'(e_ff);
                  end
                  2'd1: begin
                     alu_cmd.a = AluW'(mdur_ff);
                     alu_cmd.b = AluW'(mdur_ff);
                  end
                  2'd2: begin
                     alu_cmd.a = AluW'(d2_ff);
                     alu_cmd.b = AluW'(mdur_ff);
                  end
                  default: begin
                     alu_cmd.a = AluW'(e2_ff);
                     alu_cmd.b = AluW'(kval);
                  end
               endcase
            end else if (alu_rsp.done) begin
               wait_in = 1'b0;
               step_in = step_ff + 1'b1;
               unique case (step_ff)
                  2'd0: e2_in  = alu_rsp.result[31:0];
                  2'd1: d2_in  = alu_rsp.result[31:0];
                  2'd2: den_in = alu_rsp.result[47:0];
                  default: begin
                     num_in   = alu_rsp.result[49:0];
                     jix_in   = '0;
                     step_in  = '0;
                     state_in = S_JOINT;
                  end
               endcase
            end
         end
         S_JOINT: begin
            // Steps: issue multiply, then divide on its completion, then check.
            logic finish;
            finish = 1'b0;
            if (step_ff == 2'd0) begin
               if (done_ff) begin
                  finish = 1'b1;
               end else begin
                  alu_cmd.start = 1'b1;
                  alu_cmd.op    = ALU_MUL;
                  alu_cmd.a     = AluW'(num_ff);
                  alu_cmd.b     = AluW'(mag);
                  step_in       = 2'd1;
               end
            end else if (alu_rsp.done) begin
               if (step_ff == 2'd1) begin
                  alu_cmd.start = 1'b1;
                  alu_cmd.op    = ALU_DIV;
                  alu_cmd.a     = alu_rsp.result;
                  alu_cmd.b     = AluW'(den_ff);
                  step_in       = 2'd2;
               end else begin
                  finish = 1'b1;
               end
            end
            if (finish) begin
               step_in = '0;
               if (vsum > {1'b0, limit_ff}) begin
                  active_in = 1'b0;
                  fault_in  = 1'b1;
                  status_in = ST_FAULT;
                  state_in  = S_RESP;
               end else begin
                  sp_we  = 1'b1;
                  jix_in = jix_ff + 1'b1;
                  if (jix_ff == JW'(JOINTS - 1)) begin
                     lastrun_in = now_ff;
                     if (done_ff) active_in = 1'b0;
                     jix_in   = '0;
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_SETPOINT;
               rsp_joint_in  = 3'(jix_ff);
               rsp_sp_in     = sp_ff[jix_ff];
               rsp_last_in   = done_ff && (jix_ff == JW'(JOINTS - 1));
               jix_in        = jix_ff + 1'b1;
               if (jix_ff == JW'(JOINTS - 1)) state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_joint_in  = '0;
               rsp_sp_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= 10'd20;
         min_ff       <= 16'd20;
         max_ff       <= 16'd2000;
         limit_ff     <= '1;
         active_ff    <= 1'b0;
         fault_ff     <= 1'b0;
         mstart_ff    <= '0;
         mdur_ff      <= '0;
         lastrun_ff   <= '0;
         wait_ff      <= 1'b0;
         step_ff      <= '0;
         jix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         fault_ff     <= fault_in;
         mstart_ff    <= mstart_in;
         mdur_ff      <= mdur_in;
         lastrun_ff   <= lastrun_in;
         wait_ff      <= wait_in;
         step_ff      <= step_in;
         jix_ff       <= jix_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PERIOD: period_ff <= csr_wdata[9:0];
               CSR_MIN:    min_ff    <= csr_wdata;
               CSR_MAX:    max_ff    <= csr_wdata;
               CSR_LIMIT:  limit_ff  <= csr_wdata[P-1:0];
               default: ;
            endcase
         end
      end
      now_ff        <= now_in;
      e_ff          <= e_in;
      done_ff       <= done_in;
      e2_ff         <= e2_in;
      d2_ff         <= d2_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_joint_ff  <= rsp_joint_in;
      rsp_sp_ff     <= rsp_sp_in;
      rsp_last_ff   <= rsp_last_in;
      if (load_we) begin
         start_mem[JW'(req_joint)]  <= req_spos;
         target_mem[JW'(req_joint)] <= req_tpos;
      end
      if (sp_we) sp_ff[jix_ff] <= sp_val;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspW'({rsp_sp_ff, rsp_joint_ff, rsp_status_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/cjtg_checker.sv
module cjtg_checker #(
   parameter int POSITION_BITS = 12,
   localparam int RspW = ((6 + POSITION_BITS + 7) / 8) * 8
) (
   input logic            clock,
   input logic            reset,
   input logic            rsp_tvalid,
   input logic            rsp_tready,
   input logic [RspW-1:0] rsp_tdata,
   input logic            rsp_tlast
);
   import cjtg_pkg::*;

   // A result beat that is held back keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_SETPOINT |-> rsp_tlast &&
      rsp_tdata[RspW-1:3] == '0)
      else $error("status beat with joint, setpoint or missing last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] == ST_SETPOINT || rsp_tdata[2:0] == ST_STARTED ||
      rsp_tdata[2:0] == ST_REJECTED || rsp_tdata[2:0] == ST_ABORTED ||
      rsp_tdata[2:0] == ST_FAULT || rsp_tdata[2:0] == ST_CLEARED)
      else $error("unknown status code");

   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind cubic_joint_trajectory_generator cjtg_checker #(.POSITION_BITS(POSITION_BITS)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
